>>> hdl/tqs_pkg.sv
//------------------------------------------------------------------------------
// tqs_pkg
// Types and codes shared by the timer queue scheduler and its testbench.
//------------------------------------------------------------------------------
package tqs_pkg;

	typedef enum logic [2:0] {
		MODE_ADD_ONCE   = 3'd0,
		MODE_ADD_REPEAT = 3'd1,
		MODE_ADD_TICK   = 3'd2,
		MODE_CANCEL     = 3'd3,
		MODE_SCHEDULE   = 3'd4,
		MODE_CLEAR      = 3'd5,
		MODE_RSVD6      = 3'd6,
		MODE_RSVD7      = 3'd7
	} mode_t;

	typedef enum logic [1:0] {
		KIND_ADDED = 2'd0,
		KIND_FIRED = 2'd1,
		KIND_DONE  = 2'd2,
		KIND_FULL  = 2'd3
	} kind_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] duration;
		logic [31:0] timer_id;
		logic [47:0] now_time;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] result_id;
		logic        last;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CMD,
		ST_TICK_SCAN,
		ST_TICK_EMIT,
		ST_DUE_SCAN,
		ST_DUE_EMIT,
		ST_DONE,
		ST_WAIT
	} state_t;

	localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

endpackage

>>> hdl/timer_queue_scheduler.sv
//------------------------------------------------------------------------------
// timer_queue_scheduler
// Timer table with id allocation, cancel, clear and ordered firing.
//------------------------------------------------------------------------------
// One request is worked at a time. Add, cancel, clear and the reserved modes
// are answered from the command state. A schedule needs a command step, then
// one sweep per firing (the slot memory is read one entry per cycle and each
// firing is found by a full sweep), two closing sweeps that end the tick pass
// and the due pass, and a final result. Results leave through an output
// register, so every result that is not taken at once stalls the block until
// it is taken.
module timer_queue_scheduler #(
	parameter int SLOTS      = 16,
	parameter int MAX_EVENTS = 63
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  tqs_pkg::req_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output tqs_pkg::rsp_t  out_data
);
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int EW = 6;

	// Per-slot flags live in flip-flops; id, period and deadline in memory.
	logic [SLOTS-1:0] valid_q, repeat_q, tick_q, done_q;
	logic [31:0] id_mem [SLOTS];
	logic [31:0] per_mem [SLOTS];
	logic [47:0] dl_mem [SLOTS];

	tqs_pkg::state_t state_q, state_d;
	tqs_pkg::req_t   req_q;
	logic [31:0] next_id_q;
	logic [47:0] time_q;
	logic [CW-1:0] scan_q;
	logic [SW-1:0] rd_addr;
	logic          rd_en_s1;
	logic [SW-1:0] rd_idx_s1;
	logic [31:0]   rd_id_s1, rd_per_s1;
	logic [47:0]   rd_dl_s1;
	logic          best_v_q;
	logic [SW-1:0] best_q;
	logic [31:0]   best_id_q, best_per_q;
	logic [47:0]   best_dl_q;
	logic [EW-1:0] nev_q;
	logic          free_v_q;
	logic [SW-1:0] free_q;

	// Id match for cancel is kept per slot, refreshed on every id write.
	logic [SLOTS-1:0] cancel_hit;
	logic [31:0] id_shadow [SLOTS];

	logic scan_end, cand, better, out_free, load_out;
	logic [48:0] sum;
	logic [47:0] sat;

	assign in_ready = (state_q == tqs_pkg::ST_IDLE);
	assign out_free = !out_valid || out_ready;
	assign rd_addr  = scan_q[SW-1:0];
	assign scan_end = (scan_q == CW'(SLOTS));

	assign load_out = out_free && (
		(state_q == tqs_pkg::ST_CMD && req_q.mode != tqs_pkg::MODE_SCHEDULE) ||
		((state_q == tqs_pkg::ST_TICK_EMIT || state_q == tqs_pkg::ST_DUE_EMIT) &&
			best_v_q && nev_q != EW'(MAX_EVENTS)) ||
		(state_q == tqs_pkg::ST_DONE));

	always_ff @(posedge clk) begin
		if (scan_q < CW'(SLOTS)) begin
			rd_id_s1  <= id_mem[rd_addr];
			rd_per_s1 <= per_mem[rd_addr];
			rd_dl_s1  <= dl_mem[rd_addr];
		end
		rd_idx_s1 <= rd_addr;
	end

	always_comb begin
		cand   = 1'b0;
		better = 1'b0;
		if (state_q == tqs_pkg::ST_TICK_SCAN) begin
			cand   = valid_q[rd_idx_s1] && tick_q[rd_idx_s1] && !done_q[rd_idx_s1];
			better = !best_v_q || (rd_id_s1 < best_id_q);
		end else begin
			cand   = valid_q[rd_idx_s1] && !tick_q[rd_idx_s1] && (rd_dl_s1 <= time_q);
			better = !best_v_q || (rd_dl_s1 < best_dl_q) ||
				((rd_dl_s1 == best_dl_q) && (rd_id_s1 < best_id_q));
		end
	end

	always_comb begin
		if (state_q == tqs_pkg::ST_DUE_EMIT) begin
			sum = {1'b0, best_dl_q} + {17'd0, best_per_q};
		end else begin
			sum = {1'b0, time_q} + {17'd0, req_q.duration};
		end
		sat = sum[48] ? tqs_pkg::TIME_MAX : sum[47:0];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tqs_pkg::ST_IDLE:      if (in_valid) state_d = tqs_pkg::ST_CMD;
			tqs_pkg::ST_CMD: begin
				if (req_q.mode == tqs_pkg::MODE_SCHEDULE) begin
					state_d = tqs_pkg::ST_TICK_SCAN;
				end else if (out_free) begin
					state_d = tqs_pkg::ST_IDLE;
				end
			end
			tqs_pkg::ST_TICK_SCAN: if (rd_en_s1 && scan_end) state_d = tqs_pkg::ST_TICK_EMIT;
			tqs_pkg::ST_TICK_EMIT: begin
				if (!best_v_q || nev_q == EW'(MAX_EVENTS)) begin
					state_d = tqs_pkg::ST_DUE_SCAN;
				end else if (out_free) begin
					state_d = tqs_pkg::ST_TICK_SCAN;
				end
			end
			tqs_pkg::ST_DUE_SCAN:  if (rd_en_s1 && scan_end) state_d = tqs_pkg::ST_DUE_EMIT;
			tqs_pkg::ST_DUE_EMIT: begin
				if (!best_v_q || nev_q == EW'(MAX_EVENTS)) begin
					state_d = tqs_pkg::ST_DONE;
				end else if (out_free) begin
					state_d = tqs_pkg::ST_DUE_SCAN;
				end
			end
			tqs_pkg::ST_DONE:      if (out_free) state_d = tqs_pkg::ST_IDLE;
			default:               state_d = tqs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tqs_pkg::ST_IDLE;
			valid_q   <= '0;
			repeat_q  <= '0;
			tick_q    <= '0;
			done_q    <= '0;
			next_id_q <= '0;
			time_q    <= '0;
			out_valid <= 1'b0;
			scan_q    <= '0;
			rd_en_s1  <= 1'b0;
			best_v_q  <= 1'b0;
			nev_q     <= '0;
		end else begin
			state_q <= state_d;
			if (load_out) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			unique case (state_q)
				tqs_pkg::ST_IDLE: begin
					scan_q   <= '0;
					rd_en_s1 <= 1'b0;
					best_v_q <= 1'b0;
					nev_q    <= '0;
					done_q   <= '0;
				end
				tqs_pkg::ST_CMD: begin
					if (req_q.mode == tqs_pkg::MODE_SCHEDULE) begin
						time_q <= req_q.now_time;
					end
				end
				tqs_pkg::ST_TICK_SCAN, tqs_pkg::ST_DUE_SCAN: begin
					if (!scan_end) scan_q <= scan_q + 1'b1;
					rd_en_s1 <= !scan_end;
					if (rd_en_s1 && cand && better) begin
						best_v_q   <= 1'b1;
						best_q     <= rd_idx_s1;
						best_id_q  <= rd_id_s1;
						best_per_q <= rd_per_s1;
						best_dl_q  <= rd_dl_s1;
					end
				end
				tqs_pkg::ST_TICK_EMIT, tqs_pkg::ST_DUE_EMIT: begin
					scan_q   <= '0;
					rd_en_s1 <= 1'b0;
					if (best_v_q && nev_q != EW'(MAX_EVENTS) && out_free) begin
						best_v_q <= 1'b0;
						nev_q    <= nev_q + 1'b1;
						if (state_q == tqs_pkg::ST_TICK_EMIT) begin
							done_q[best_q] <= 1'b1;
						end else if (!repeat_q[best_q]) begin
							valid_q[best_q] <= 1'b0;
						end
					end else if (!best_v_q || nev_q == EW'(MAX_EVENTS)) begin
						best_v_q <= 1'b0;
					end
				end
				default: ;
			endcase
			// Command results (add, cancel, clear).
			if (state_q == tqs_pkg::ST_CMD && req_q.mode != tqs_pkg::MODE_SCHEDULE &&
					out_free) begin
				if (req_q.mode == tqs_pkg::MODE_ADD_ONCE ||
						req_q.mode == tqs_pkg::MODE_ADD_REPEAT ||
						req_q.mode == tqs_pkg::MODE_ADD_TICK) begin
					if (free_v_q) begin
						next_id_q         <= next_id_q + 1'b1;
						valid_q[free_q]   <= 1'b1;
						repeat_q[free_q]  <= (req_q.mode == tqs_pkg::MODE_ADD_REPEAT) &&
							(req_q.duration != '0);
						tick_q[free_q]    <= (req_q.mode == tqs_pkg::MODE_ADD_TICK) ||
							((req_q.mode == tqs_pkg::MODE_ADD_REPEAT) &&
							(req_q.duration == '0));
					end
				end else if (req_q.mode == tqs_pkg::MODE_CANCEL) begin
					for (int i = 0; i < SLOTS; i++) begin
						if (cancel_hit[i]) valid_q[i] <= 1'b0;
					end
				end else if (req_q.mode == tqs_pkg::MODE_CLEAR) begin
					valid_q <= '0;
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			cancel_hit[i] = valid_q[i] && (id_shadow[i] == req_q.timer_id);
		end
	end

	always_comb begin
		free_v_q = 1'b0;
		free_q   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_v_q = 1'b1;
				free_q   = SW'(i);
			end
		end
	end

	// Payload registers and memory writes.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) req_q <= in_data;
		if (state_q == tqs_pkg::ST_CMD && out_free &&
				(req_q.mode == tqs_pkg::MODE_ADD_ONCE ||
				req_q.mode == tqs_pkg::MODE_ADD_REPEAT ||
				req_q.mode == tqs_pkg::MODE_ADD_TICK)) begin
			out_data.kind      <= free_v_q ? tqs_pkg::KIND_ADDED : tqs_pkg::KIND_FULL;
			out_data.result_id <= free_v_q ? next_id_q + 1'b1 : '0;
			out_data.last      <= 1'b1;
			if (free_v_q) begin
				id_mem[free_q]    <= next_id_q + 1'b1;
				id_shadow[free_q] <= next_id_q + 1'b1;
				per_mem[free_q]   <= (req_q.mode == tqs_pkg::MODE_ADD_TICK) ? '0 :
					req_q.duration;
				dl_mem[free_q]    <= (req_q.mode == tqs_pkg::MODE_ADD_TICK) ? time_q : sat;
			end
		end else if (state_q == tqs_pkg::ST_CMD && out_free &&
				req_q.mode != tqs_pkg::MODE_SCHEDULE) begin
			out_data.kind      <= tqs_pkg::KIND_DONE;
			out_data.result_id <= '0;
			out_data.last      <= 1'b1;
		end else if ((state_q == tqs_pkg::ST_TICK_EMIT ||
				state_q == tqs_pkg::ST_DUE_EMIT) && best_v_q &&
				nev_q != EW'(MAX_EVENTS) && out_free) begin
			out_data.kind      <= tqs_pkg::KIND_FIRED;
			out_data.result_id <= best_id_q;
			out_data.last      <= 1'b0;
			if (state_q == tqs_pkg::ST_DUE_EMIT && repeat_q[best_q]) begin
				dl_mem[best_q] <= sat;
			end
		end else if (state_q == tqs_pkg::ST_DONE && out_free) begin
			out_data.kind      <= tqs_pkg::KIND_DONE;
			out_data.result_id <= '0;
			out_data.last      <= 1'b1;
		end
	end

	// A result is never loaded over one that has not been taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("result overwritten while stalled");
	// No more firings than the limit in one schedule.
	assert property (@(posedge clk) disable iff (!arst_n)
		nev_q <= EW'(MAX_EVENTS))
		else $error("firing count beyond limit");
	// A new request is only taken while no command is in flight.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == tqs_pkg::ST_CMD))
		else $error("request accepted outside idle");

endmodule

>>> sim/timer_queue_scheduler_tb.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// timer_queue_scheduler_tb
// Drives timer commands into the scheduler and checks every answer against an
// in-bench model of the timer table, under several idle and stall patterns.
//------------------------------------------------------------------------------

class timer_table_board;
	localparam int NSLOT = 16;
	localparam int FIRE_LIMIT = 63;

	bit          used [NSLOT];
	bit          rep [NSLOT];
	bit          tick [NSLOT];
	logic [31:0] ident [NSLOT];
	logic [31:0] period [NSLOT];
	logic [47:0] due_at [NSLOT];
	logic [31:0] last_id;
	logic [47:0] clock_now;
	tqs_pkg::rsp_t pending [$];
	int errors;
	int checked;
	int fired_seen;
	int full_seen;

	function new();
		foreach (used[i]) begin
			used[i] = 0;
			rep[i] = 0;
			tick[i] = 0;
		end
		last_id = '0;
		clock_now = '0;
		errors = 0;
		checked = 0;
		fired_seen = 0;
		full_seen = 0;
	endfunction

	function logic [47:0] sat_sum(logic [47:0] a, logic [31:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {17'd0, b};
		return s[48] ? tqs_pkg::TIME_MAX : s[47:0];
	endfunction

	function void push(tqs_pkg::kind_t k, logic [31:0] id, logic lst);
		tqs_pkg::rsp_t r;
		r.kind = k;
		r.result_id = id;
		r.last = lst;
		pending.push_back(r);
	endfunction

	function void take_slot(bit is_rep, bit is_tick, logic [31:0] dur);
		for (int i = 0; i < NSLOT; i++) begin
			if (!used[i]) begin
				last_id = last_id + 32'd1;
				used[i] = 1;
				rep[i] = is_rep;
				tick[i] = is_tick;
				ident[i] = last_id;
				period[i] = dur;
				due_at[i] = sat_sum(clock_now, dur);
				push(tqs_pkg::KIND_ADDED, last_id, 1'b1);
				return;
			end
		end
		push(tqs_pkg::KIND_FULL, '0, 1'b1);
	endfunction

	function void run_schedule(logic [47:0] now);
		bit done [NSLOT];
		int n;
		int best;
		n = 0;
		clock_now = now;
		foreach (done[i]) done[i] = 0;
		while (n < FIRE_LIMIT) begin
			best = -1;
			for (int i = 0; i < NSLOT; i++)
				if (used[i] && tick[i] && !done[i] && (best < 0 || ident[i] < ident[best]))
					best = i;
			if (best < 0)
				break;
			done[best] = 1;
			push(tqs_pkg::KIND_FIRED, ident[best], 1'b0);
			n++;
		end
		while (n < FIRE_LIMIT) begin
			best = -1;
			for (int i = 0; i < NSLOT; i++)
				if (used[i] && !tick[i] && due_at[i] <= clock_now) begin
					if (best < 0 || due_at[i] < due_at[best] ||
						(due_at[i] == due_at[best] && ident[i] < ident[best]))
						best = i;
				end
			if (best < 0)
				break;
			push(tqs_pkg::KIND_FIRED, ident[best], 1'b0);
			n++;
			if (rep[best])
				due_at[best] = sat_sum(due_at[best], period[best]);
			else
				used[best] = 0;
		end
		push(tqs_pkg::KIND_DONE, '0, 1'b1);
	endfunction

	function void note_request(tqs_pkg::req_t rq);
		case (tqs_pkg::mode_t'(rq.mode))
			tqs_pkg::MODE_ADD_ONCE: take_slot(0, 0, rq.duration);
			tqs_pkg::MODE_ADD_REPEAT: begin
				if (rq.duration == 0)
					take_slot(0, 1, '0);
				else
					take_slot(1, 0, rq.duration);
			end
			tqs_pkg::MODE_ADD_TICK: take_slot(0, 1, '0);
			tqs_pkg::MODE_CANCEL: begin
				for (int i = 0; i < NSLOT; i++)
					if (used[i] && ident[i] == rq.timer_id)
						used[i] = 0;
				push(tqs_pkg::KIND_DONE, '0, 1'b1);
			end
			tqs_pkg::MODE_SCHEDULE: run_schedule(rq.now_time);
			tqs_pkg::MODE_CLEAR: begin
				foreach (used[i]) used[i] = 0;
				push(tqs_pkg::KIND_DONE, '0, 1'b1);
			end
			default: push(tqs_pkg::KIND_DONE, '0, 1'b1);
		endcase
	endfunction

	function void check_result(tqs_pkg::rsp_t got);
		tqs_pkg::rsp_t want;
		checked++;
		if (got.kind == tqs_pkg::KIND_FIRED)
			fired_seen++;
		if (got.kind == tqs_pkg::KIND_FULL)
			full_seen++;
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("%0t: unexpected result kind=%0d id=%0d last=%0b", $realtime,
					got.kind, got.result_id, got.last);
			return;
		end
		want = pending.pop_front();
		if (got.kind !== want.kind || got.result_id !== want.result_id ||
			got.last !== want.last) begin
			errors++;
			if (errors <= 10)
				$display("%0t: mismatch exp kind=%0d id=%0d last=%0b got kind=%0d id=%0d last=%0b",
					$realtime, want.kind, want.result_id, want.last,
					got.kind, got.result_id, got.last);
		end
	endfunction
endclass

module timer_queue_scheduler_tb;

	localparam longint CYCLE_LIMIT = 3000000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	tqs_pkg::req_t in_data;
	logic out_valid;
	logic out_ready;
	tqs_pkg::rsp_t out_data;

	int send_idle_pct;
	int recv_stall_pct;
	longint cycles;
	int sent;
	timer_table_board board;

	timer_queue_scheduler DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		board = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cycles = 0;
		sent = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// The receiver stalls at random; results are checked at the accepting edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				board.check_result(out_data);
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_request(logic [2:0] mode, logic [31:0] dur, logic [31:0] id,
		logic [47:0] now);
		tqs_pkg::req_t rq;
		rq.mode = mode;
		rq.duration = dur;
		rq.timer_id = id;
		rq.now_time = now;
		while ($urandom_range(99) < send_idle_pct)
			@(posedge clk);
		in_valid <= 1'b1;
		in_data <= rq;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_request(rq);
		sent++;
		in_valid <= 1'b0;
		// The block is busy with the request for at least this cycle.
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// Mostly adds and schedules near the current time, so timers actually fire.
	task automatic random_request();
		int pick;
		logic [31:0] dur;
		logic [47:0] now;
		pick = $urandom_range(99);
		dur = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(40);
		now = board.clock_now + 48'($urandom_range(60));
		if ($urandom_range(14) == 0)
			now = 48'({$urandom(), $urandom()});
		else if ($urandom_range(14) == 0)
			now = board.clock_now - 48'($urandom_range(20));
		if (pick < 22)
			send_request(tqs_pkg::MODE_ADD_ONCE, dur, $urandom(), 48'($urandom()));
		else if (pick < 40)
			send_request(tqs_pkg::MODE_ADD_REPEAT, ($urandom_range(5) == 0) ? 32'd0 : dur,
				$urandom(), 48'($urandom()));
		else if (pick < 46)
			send_request(tqs_pkg::MODE_ADD_TICK, $urandom(), $urandom(), 48'($urandom()));
		else if (pick < 58)
			send_request(tqs_pkg::MODE_CANCEL, $urandom(),
				($urandom_range(3) == 0) ? $urandom() : board.last_id - $urandom_range(8),
				48'($urandom()));
		else if (pick < 92)
			send_request(tqs_pkg::MODE_SCHEDULE, $urandom(), $urandom(), now);
		else if (pick < 95)
			send_request(tqs_pkg::MODE_CLEAR, $urandom(), $urandom(), 48'($urandom()));
		else
			send_request(3'($urandom_range(7)), $urandom(), $urandom(),
				48'({$urandom(), $urandom()}));
	endtask

	initial begin
		#1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every mode, extreme fields, table full, firing limit.
		send_request(tqs_pkg::MODE_SCHEDULE, '0, '0, 48'd0);
		send_request(tqs_pkg::MODE_ADD_ONCE, 32'd0, '0, '0);
		send_request(tqs_pkg::MODE_ADD_ONCE, 32'hFFFF_FFFF, '1, '1);
		send_request(tqs_pkg::MODE_ADD_REPEAT, 32'd0, '0, '0);
		send_request(tqs_pkg::MODE_ADD_REPEAT, 32'd1, '0, '0);
		send_request(tqs_pkg::MODE_ADD_TICK, 32'd5, '0, '0);
		send_request(tqs_pkg::MODE_ADD_ONCE, 32'd3, '0, '0);
		send_request(tqs_pkg::MODE_ADD_ONCE, 32'd3, '0, '0);
		send_request(tqs_pkg::MODE_SCHEDULE, '0, '0, 48'd10);
		send_request(tqs_pkg::MODE_CANCEL, '0, 32'd3, '0);
		send_request(tqs_pkg::MODE_CANCEL, '0, 32'hFFFF_FFFF, '0);
		send_request(tqs_pkg::MODE_RSVD6, '1, '1, '1);
		send_request(tqs_pkg::MODE_RSVD7, '0, '0, '0);
		send_request(tqs_pkg::MODE_SCHEDULE, '0, '0, 48'd2);
		for (int i = 0; i < 14; i++)
			send_request(tqs_pkg::MODE_ADD_REPEAT, 32'd1, '0, '0);
		send_request(tqs_pkg::MODE_ADD_ONCE, 32'd1, '0, '0);
		send_request(tqs_pkg::MODE_SCHEDULE, '0, '0, 48'd200);
		send_request(tqs_pkg::MODE_SCHEDULE, '0, '0, tqs_pkg::TIME_MAX);
		send_request(tqs_pkg::MODE_CLEAR, '0, '0, '0);
		send_request(tqs_pkg::MODE_ADD_ONCE, 32'hFFFF_FFFF, '0, '0);
		send_request(tqs_pkg::MODE_SCHEDULE, '0, '0, tqs_pkg::TIME_MAX);
		send_request(tqs_pkg::MODE_SCHEDULE, '0, '0, 48'd0);
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 69; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 69; end
				default: begin send_idle_pct = 6; recv_stall_pct = 6; end
			endcase
			for (int i = 0; i < 46; i++) begin
				random_request();
				if (i == 23)
					wait_drained();
			end
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		wait_drained();
		repeat (200) @(posedge clk);

		$display("Sent %0d requests, checked %0d results (%0d firings, %0d table-full answers).",
			sent, board.checked, board.fired_seen, board.full_seen);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> sim.f
hdl/tqs_pkg.sv
hdl/timer_queue_scheduler.sv
sim/timer_queue_scheduler_tb.sv
